### hw/rtl/dtet_pkg.sv
// shared types, constants and the control program of the task expiry table
`timescale 1ns / 1ps

package dtet_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int TIME_W        = 48;
	localparam int DELAY_W       = 32;
	localparam int ID_W          = 16;
	localparam int KIND_W        = 2;
	localparam int SLEEP_CFG_W   = 32;
	localparam int STEP_W        = 3;
	localparam logic [SLEEP_CFG_W-1:0] MAX_SLEEP_RST = 32'd1000;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SLEEP   = 2'd2;

	// input operations
	localparam logic OP_ADD     = 1'b0;
	localparam logic OP_SERVICE = 1'b1;

	// program steps
	localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
	localparam logic [STEP_W-1:0] STEP_ADD  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_INIT = 3'd2;
	localparam logic [STEP_W-1:0] STEP_SCAN = 3'd3;
	localparam logic [STEP_W-1:0] STEP_END  = 3'd4;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_ADD,
		ACT_INIT,
		ACT_SCAN,
		ACT_END
	} act_t;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_SERVICE,
		COND_EMPTY,
		COND_SCAN_LAST
	} cond_t;

	typedef struct packed {
		logic              wait_in;
		act_t              act;
		cond_t             cond;
		logic [STEP_W-1:0] jump_step;
		logic [STEP_W-1:0] next_step;
	} ucode_word_t;

	// sequencer to datapath
	typedef struct packed {
		act_t act;
		logic take;
	} dp_ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic is_service;
		logic empty;
		logic scan_last;
		logic hold;
	} dp_status_t;

	// control store
	function automatic ucode_word_t ucode(input logic [STEP_W-1:0] step);
		ucode_word_t w;
		w = '{wait_in: 1'b0, act: ACT_NONE, cond: COND_ALWAYS,
			jump_step: STEP_IDLE, next_step: STEP_IDLE};
		case (step)
			STEP_IDLE: begin
				w = '{wait_in: 1'b1, act: ACT_NONE, cond: COND_SERVICE,
					jump_step: STEP_INIT, next_step: STEP_ADD};
			end
			STEP_ADD: begin
				w = '{wait_in: 1'b0, act: ACT_ADD, cond: COND_ALWAYS,
					jump_step: STEP_IDLE, next_step: STEP_IDLE};
			end
			STEP_INIT: begin
				w = '{wait_in: 1'b0, act: ACT_INIT, cond: COND_EMPTY,
					jump_step: STEP_END, next_step: STEP_SCAN};
			end
			STEP_SCAN: begin
				w = '{wait_in: 1'b0, act: ACT_SCAN, cond: COND_SCAN_LAST,
					jump_step: STEP_END, next_step: STEP_SCAN};
			end
			STEP_END: begin
				w = '{wait_in: 1'b0, act: ACT_END, cond: COND_ALWAYS,
					jump_step: STEP_IDLE, next_step: STEP_IDLE};
			end
			default: begin
				w = '{wait_in: 1'b0, act: ACT_NONE, cond: COND_ALWAYS,
					jump_step: STEP_IDLE, next_step: STEP_IDLE};
			end
		endcase
		return w;
	endfunction

endpackage

### hw/rtl/dtet_in_if.sv
// request channel: add or service items
`timescale 1ns / 1ps

interface dtet_in_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [dtet_pkg::TIME_W-1:0]  now_ms;
	logic [dtet_pkg::DELAY_W-1:0] lag_ms;
	logic [dtet_pkg::ID_W-1:0]    task_id;

	modport source (output valid, output operation, output now_ms, output lag_ms,
		output task_id, input ready);
	modport sink (input valid, input operation, input now_ms, input lag_ms,
		input task_id, output ready);
endinterface

### hw/rtl/dtet_out_if.sv
// result channel: acknowledges, expired ids and sleep reports
`timescale 1ns / 1ps

interface dtet_out_if;
	logic                        valid;
	logic                        ready;
	logic [dtet_pkg::KIND_W-1:0] kind;
	logic [dtet_pkg::ID_W-1:0]   expired_id;
	logic [dtet_pkg::TIME_W-1:0] sleep_ms;
	logic                        rejected;
	logic                        last;

	modport source (output valid, output kind, output expired_id, output sleep_ms,
		output rejected, output last, input ready);
	modport sink (input valid, input kind, input expired_id, input sleep_ms,
		input rejected, input last, output ready);
endinterface

### hw/rtl/dtet_cfg_if.sv
// configuration write channel for the max sleep register
`timescale 1ns / 1ps

interface dtet_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [dtet_pkg::SLEEP_CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/dtet_sequencer.sv
// step counter and control store walker
`timescale 1ns / 1ps

module dtet_sequencer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  dtet_pkg::dp_status_t   status,
	output dtet_pkg::dp_ctl_t      ctl
);

	logic [dtet_pkg::STEP_W-1:0] step_q;
	dtet_pkg::ucode_word_t       cw;
	logic                        advance;
	logic                        cond_true;

	assign cw = dtet_pkg::ucode(step_q);

	always_comb begin
		case (cw.cond)
			dtet_pkg::COND_ALWAYS:    cond_true = 1'b1;
			dtet_pkg::COND_SERVICE:   cond_true = status.is_service;
			dtet_pkg::COND_EMPTY:     cond_true = status.empty;
			dtet_pkg::COND_SCAN_LAST: cond_true = status.scan_last;
			default:                  cond_true = 1'b1;
		endcase
	end

	// waiting steps move on a transfer, others unless the datapath holds
	assign advance  = cw.wait_in ? in_valid : !status.hold;
	assign in_ready = cw.wait_in;
	assign ctl.act  = cw.act;
	assign ctl.take = cw.wait_in && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dtet_pkg::STEP_IDLE;
		end else if (advance) begin
			step_q <= cond_true ? cw.jump_step : cw.next_step;
		end
	end

endmodule

### hw/rtl/dtet_datapath.sv
// task memory, scan and compaction datapath, result register
`timescale 1ns / 1ps

module dtet_datapath #(
	parameter int SLOTS = dtet_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dtet_pkg::dp_ctl_t                ctl,
	output dtet_pkg::dp_status_t             status,
	input  logic                             in_operation,
	input  logic [dtet_pkg::TIME_W-1:0]      in_now_ms,
	input  logic [dtet_pkg::DELAY_W-1:0]     in_lag_ms,
	input  logic [dtet_pkg::ID_W-1:0]        in_task_id,
	input  logic [dtet_pkg::SLEEP_CFG_W-1:0] max_sleep,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [dtet_pkg::KIND_W-1:0]      out_kind,
	output logic [dtet_pkg::ID_W-1:0]        out_expired_id,
	output logic [dtet_pkg::TIME_W-1:0]      out_sleep_ms,
	output logic                             out_rejected,
	output logic                             out_last
);

	localparam int CW   = $clog2(SLOTS + 1);
	localparam int IW   = $clog2(SLOTS);
	localparam int TW   = dtet_pkg::TIME_W;
	localparam int IDW  = dtet_pkg::ID_W;
	localparam int EW   = TW + IDW;

	logic [EW-1:0] mem [SLOTS];

	logic [TW-1:0]               now_q;
	logic [dtet_pkg::DELAY_W-1:0] delay_q;
	logic [IDW-1:0]              id_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               scan_q;
	logic [CW-1:0]               keep_q;
	logic                        have_min_q;
	logic [TW-1:0]               min_q;
	logic [EW-1:0]               rd_s1;

	logic                        out_valid_q;
	logic [dtet_pkg::KIND_W-1:0] out_kind_q;
	logic [IDW-1:0]              out_id_q;
	logic [TW-1:0]               out_sleep_q;
	logic                        out_rej_q;
	logic                        out_last_q;

	logic          out_free;
	logic          full;
	logic [TW:0]   sum;
	logic [TW-1:0] add_dl;
	logic [TW-1:0] rd_dl;
	logic [IDW-1:0] rd_id;
	logic          expired;
	logic          scan_last;
	logic          hold;
	logic          run;

	logic          we;
	logic [IW-1:0] wa;
	logic [EW-1:0] wd;
	logic          re;
	logic [IW-1:0] ra;

	logic                        emit;
	logic [dtet_pkg::KIND_W-1:0] emit_kind;
	logic [IDW-1:0]              emit_id;
	logic [TW-1:0]               emit_sleep;
	logic                        emit_rej;
	logic                        emit_last;

	assign out_free  = !out_valid_q || out_ready;
	assign full      = (count_q == CW'(SLOTS));
	assign sum       = {1'b0, now_q} + {{(TW + 1 - dtet_pkg::DELAY_W){1'b0}}, delay_q};
	assign add_dl    = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
	assign rd_dl     = rd_s1[EW-1:IDW];
	assign rd_id     = rd_s1[IDW-1:0];
	assign expired   = (rd_dl <= now_q);
	assign scan_last = (scan_q == count_q);

	always_comb begin
		case (ctl.act)
			dtet_pkg::ACT_ADD:  hold = !out_free;
			dtet_pkg::ACT_SCAN: hold = expired && !out_free;
			dtet_pkg::ACT_END:  hold = !out_free;
			default:            hold = 1'b0;
		endcase
	end

	assign run = !hold;

	assign status.is_service = (in_operation == dtet_pkg::OP_SERVICE);
	assign status.empty      = (count_q == '0);
	assign status.scan_last  = scan_last;
	assign status.hold       = hold;

	// memory ports and result selection
	always_comb begin
		we         = 1'b0;
		wa         = keep_q[IW-1:0];
		wd         = rd_s1;
		re         = 1'b0;
		ra         = scan_q[IW-1:0];
		emit       = 1'b0;
		emit_kind  = dtet_pkg::KIND_ACK;
		emit_id    = '0;
		emit_sleep = '0;
		emit_rej   = 1'b0;
		emit_last  = 1'b0;
		case (ctl.act)
			dtet_pkg::ACT_ADD: begin
				if (run) begin
					we        = !full;
					wa        = count_q[IW-1:0];
					wd        = {add_dl, id_q};
					emit      = 1'b1;
					emit_rej  = full;
					emit_last = 1'b1;
				end
			end
			dtet_pkg::ACT_INIT: begin
				re = (count_q != '0);
				ra = '0;
			end
			dtet_pkg::ACT_SCAN: begin
				if (run) begin
					we        = !expired;
					re        = !scan_last;
					emit      = expired;
					emit_kind = dtet_pkg::KIND_EXPIRED;
					emit_id   = rd_id;
				end
			end
			dtet_pkg::ACT_END: begin
				if (run) begin
					emit       = 1'b1;
					emit_kind  = dtet_pkg::KIND_SLEEP;
					emit_sleep = have_min_q ? (min_q - now_q)
						: {{(TW - dtet_pkg::SLEEP_CFG_W){1'b0}}, max_sleep};
					emit_last  = 1'b1;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_s1 <= mem[ra];
		end
	end

	// latched item
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			now_q   <= in_now_ms;
			delay_q <= in_lag_ms;
			id_q    <= in_task_id;
		end
	end

	// running minimum over kept entries
	always_ff @(posedge clk) begin
		if (ctl.act == dtet_pkg::ACT_SCAN && run && !expired) begin
			if (!have_min_q || rd_dl < min_q) begin
				min_q <= rd_dl;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_q     <= '0;
			keep_q     <= '0;
			have_min_q <= 1'b0;
		end else begin
			case (ctl.act)
				dtet_pkg::ACT_ADD: begin
					if (run && !full) begin
						count_q <= count_q + 1'b1;
					end
				end
				dtet_pkg::ACT_INIT: begin
					scan_q     <= (count_q != '0) ? CW'(1) : '0;
					keep_q     <= '0;
					have_min_q <= 1'b0;
				end
				dtet_pkg::ACT_SCAN: begin
					if (run) begin
						if (!expired) begin
							keep_q     <= keep_q + 1'b1;
							have_min_q <= 1'b1;
						end
						if (!scan_last) begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				dtet_pkg::ACT_END: begin
					if (run) begin
						count_q <= keep_q;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q  <= emit_kind;
			out_id_q    <= emit_id;
			out_sleep_q <= emit_sleep;
			out_rej_q   <= emit_rej;
			out_last_q  <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = out_kind_q;
	assign out_expired_id = out_id_q;
	assign out_sleep_ms   = out_sleep_q;
	assign out_rejected   = out_rej_q;
	assign out_last       = out_last_q;

endmodule

### hw/rtl/delayed_task_expiry_table.sv
// top level of the delayed task expiry table
`timescale 1ns / 1ps

// delayed task expiry table: holds up to SLOTS pending tasks in insertion
// order, each an id with an absolute deadline (now_ms + lag_ms, saturated
// at the 48-bit time range). an add item answers with one acknowledge,
// flagged rejected when the table is full. a service item sends one expired
// result per task whose deadline is at or before now_ms, in table order,
// then one sleep report: the earliest remaining deadline minus now_ms, or
// max_sleep when nothing is left. the last result of every item has last
// set. an add is accepted, then stored and answered; a service is accepted,
// initialised, scanned and closed by the sleep report. the scan walks the
// task memory through its single read port one entry per cycle, writing kept
// entries back compacted; any step with a result due waits while the result
// register is still full. max_sleep resets to 1000; the user writes it
// through cfg only at an idle time; the block itself does not enforce this.
module delayed_task_expiry_table #(
	parameter int SLOTS = dtet_pkg::SLOTS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	dtet_in_if.sink   req,
	dtet_out_if.source rsp,
	dtet_cfg_if.sink  cfg
);

	// control path between sequencer and datapath
	dtet_pkg::dp_ctl_t    ctl;
	dtet_pkg::dp_status_t status;

	// configuration register, always ready for a transfer
	logic [dtet_pkg::SLEEP_CFG_W-1:0] max_sleep_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_sleep_q <= dtet_pkg::MAX_SLEEP_RST;
		end else if (cfg.valid) begin
			max_sleep_q <= cfg.data;
		end
	end

	// step counter walking the control store
	dtet_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.ctl      (ctl)
	);

	// task memory, compare and compaction, result register
	dtet_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.status         (status),
		.in_operation   (req.operation),
		.in_now_ms      (req.now_ms),
		.in_lag_ms      (req.lag_ms),
		.in_task_id     (req.task_id),
		.max_sleep      (max_sleep_q),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.out_kind       (rsp.kind),
		.out_expired_id (rsp.expired_id),
		.out_sleep_ms   (rsp.sleep_ms),
		.out_rejected   (rsp.rejected),
		.out_last       (rsp.last)
	);

endmodule
